>>> hdl/tac_pkg.sv
package tac_pkg;

  localparam int SUM_W     = 18;
  localparam int CNT_W     = 8;
  localparam int OHM_W     = 20;
  localparam int BETA_W    = 14;
  localparam int NC_W      = 7;
  localparam int CFG_W     = 20;
  localparam int IDX_W     = 3;
  localparam int TEMP_W    = 16;

  localparam int MA_W      = 40;
  localparam int MB_W      = 32;
  localparam int DIG_W     = 8;
  localparam int PROD_W    = 72;
  localparam int MUL_STEPS = 4;

  localparam int XN_W      = 40;
  localparam int K_W       = 6;
  localparam int FRAC_W    = 16;
  localparam int IT_W      = 4;
  localparam int L2_W      = 22;
  localparam int LR_W      = 24;
  localparam int DEN_W     = 41;
  localparam int DQ_W      = 54;
  localparam int DR_W      = 42;
  localparam int STEP_W    = 6;

  localparam logic [IDX_W-1:0] CFG_SAMPLE_COUNT    = 3'd0;
  localparam logic [IDX_W-1:0] CFG_SERIES_OHMS     = 3'd1;
  localparam logic [IDX_W-1:0] CFG_NOMINAL_OHMS    = 3'd2;
  localparam logic [IDX_W-1:0] CFG_BETA_VALUE      = 3'd3;
  localparam logic [IDX_W-1:0] CFG_NOMINAL_CELSIUS = 3'd4;

  localparam logic [MB_W-1:0]          LN2_Q32         = 32'd2977044472;
  localparam logic [22:0]              SCALE_Q16_CENTI = 23'd6553600;
  localparam logic [TEMP_W-1:0]        ZERO_K_CENTI    = 16'd27315;
  localparam logic [TEMP_W-1:0]        HOT_LIMIT_K     = 16'd57315;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN        = -16'sd27315;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX        = 16'sd30000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG_DIV,
    S_CHECK,
    S_MUL_RA,
    S_LOG_NORM,
    S_LOG_SQ,
    S_LOG_BIT,
    S_LN_MUL,
    S_LN_ACC,
    S_DEN_MUL,
    S_BS_MUL,
    S_NUM_MUL,
    S_TC_DIV,
    S_RESULT
  } state_t;

endpackage

>>> hdl/thermistor_average_to_celsius.sv
// Samples transfer one per cycle while no conversion runs. A sample that completes the
// configured count starts a conversion; an out-of-range average ends it early, and each
// logarithm first normalizes its argument with up to 39 shifts. An output stall holds it.
// The work is done by one shared 40x8 digit multiplier (16 squarings per logarithm,
// three logarithms) and a radix-2 divider.
// Reset is synchronous and active low; it restores the register defaults and clears the
// sample sum, the sample counter and the result channel.
module thermistor_average_to_celsius #(
  parameter int ADC_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tac_pkg::IDX_W-1:0]        cfg_index,
  input  logic [tac_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ADC_BITS-1:0]              in_adc_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [tac_pkg::TEMP_W-1:0] out_temp_centi,
  output logic                             out_of_range
);
  import tac_pkg::*;

  localparam logic [SUM_W-1:0] FULL = SUM_W'((1 << ADC_BITS) - 1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  sample_count_r;
  logic [OHM_W-1:0]  series_r;
  logic [OHM_W-1:0]  nominal_r;
  logic [BETA_W-1:0] beta_r;
  logic [NC_W-1:0]   nc_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  counter_r;

  logic [MA_W-1:0]   a_r;
  logic [MB_W-1:0]   b_r;
  logic [PROD_W-1:0] prod_r;
  logic [DQ_W-1:0]   q_r;
  logic [DR_W-1:0]   rem_r;
  logic [DR_W-1:0]   dv_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  avg_r;
  logic [XN_W-1:0]   xn_r;
  logic [K_W-1:0]    k_r;
  logic [FRAC_W-1:0] frac_r;
  logic [IT_W-1:0]   it_r;
  logic [1:0]        sel_r;
  logic signed [LR_W-1:0]  lr_r;
  logic signed [DEN_W-1:0] den_r;
  logic signed [TEMP_W-1:0] res_temp_r;
  logic              res_oor_r;
  logic              out_valid_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  logic              out_oor_r;

  logic              accept;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  target;
  logic              emit;
  logic [MA_W+DIG_W-1:0] mul_pp;
  logic [PROD_W-1:0] prod_step;
  logic              mul_last;
  logic [DR_W:0]     div_sh;
  logic              div_ge;
  logic [DR_W:0]     div_diff;
  logic [DR_W-1:0]   div_rem;
  logic [DQ_W-1:0]   q_step;
  logic [31:0]       m2;
  logic              sq_bit;
  logic [30:0]       m_new;
  logic [FRAC_W-1:0] frac_new;
  logic [L2_W-1:0]   ln_val;
  logic signed [LR_W-1:0] ln_ext;
  logic signed [LR_W-1:0] lr_acc;
  logic [LR_W-1:0]   lr_mag;
  logic [TEMP_W-1:0] t0c;
  logic [OHM_W-1:0]  ser_eff;
  logic [OHM_W-1:0]  nom_eff;
  logic [BETA_W-1:0] beta_eff;
  logic [SUM_W-1:0]  avg_div;
  logic              avg_oor;
  logic              can_load;
  logic signed [TEMP_W-1:0] tc_temp;

  assign accept   = in_valid && in_ready;
  assign sum_add  = {1'b0, sum_r} + (SUM_W+1)'(in_adc_sample);
  assign sum_sat  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign cnt_inc  = counter_r + 1'b1;
  assign target   = (sample_count_r == '0) ? CNT_W'(1) : sample_count_r;
  assign emit     = (cnt_inc != '0) && (cnt_inc >= target);

  assign mul_pp    = a_r * b_r[DIG_W-1:0];
  assign prod_step = {mul_pp, 24'b0} + (prod_r >> DIG_W);
  assign mul_last  = (step_r == STEP_W'(MUL_STEPS - 1));

  assign div_sh   = {rem_r, q_r[DQ_W-1]};
  assign div_ge   = (div_sh >= {1'b0, dv_r});
  assign div_diff = div_sh - {1'b0, dv_r};
  assign div_rem  = div_ge ? div_diff[DR_W-1:0] : div_sh[DR_W-1:0];
  assign q_step   = {q_r[DQ_W-2:0], div_ge};

  assign m2       = prod_r[61:30];
  assign sq_bit   = m2[31];
  assign m_new    = sq_bit ? m2[31:1] : m2[30:0];
  assign frac_new = {frac_r[FRAC_W-2:0], sq_bit};

  assign ln_val = prod_r[53:32] + L2_W'(prod_r[31]);
  assign ln_ext = {2'b00, ln_val};
  assign lr_acc = (sel_r == 2'd0) ? ln_ext : lr_r - ln_ext;
  assign lr_mag = lr_acc[LR_W-1] ? LR_W'(-lr_acc) : LR_W'(lr_acc);

  assign t0c      = TEMP_W'(nc_r) * 16'd100 + ZERO_K_CENTI;
  assign ser_eff  = (series_r == '0) ? OHM_W'(1) : series_r;
  assign nom_eff  = (nominal_r == '0) ? OHM_W'(1) : nominal_r;
  assign beta_eff = (beta_r == '0) ? BETA_W'(1) : beta_r;

  assign avg_div  = q_r[SUM_W-1:0];
  assign avg_oor  = (avg_div == '0) || (avg_div >= FULL);
  assign can_load = !out_valid_r || out_ready;
  assign tc_temp  = (q_step > DQ_W'(HOT_LIMIT_K)) ? TEMP_MAX
                                                   : $signed(q_step[TEMP_W-1:0] - ZERO_K_CENTI);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (accept && emit) state_nxt = S_AVG_DIV;
      S_AVG_DIV:  if (step_r == STEP_W'(SUM_W - 1)) state_nxt = S_CHECK;
      S_CHECK:    state_nxt = avg_oor ? S_RESULT : S_MUL_RA;
      S_MUL_RA:   if (mul_last) state_nxt = S_LOG_NORM;
      S_LOG_NORM: if (xn_r[XN_W-1]) state_nxt = S_LOG_SQ;
      S_LOG_SQ:   if (mul_last) state_nxt = S_LOG_BIT;
      S_LOG_BIT:  state_nxt = (it_r == '1) ? S_LN_MUL : S_LOG_SQ;
      S_LN_MUL:   if (mul_last) state_nxt = S_LN_ACC;
      S_LN_ACC:   state_nxt = (sel_r == 2'd2) ? S_DEN_MUL : S_LOG_NORM;
      S_DEN_MUL:  if (mul_last) state_nxt = S_BS_MUL;
      S_BS_MUL:   if (mul_last) state_nxt = S_NUM_MUL;
      S_NUM_MUL: begin
        if (mul_last) state_nxt = (den_r[DEN_W-1] || den_r == '0) ? S_RESULT : S_TC_DIV;
      end
      S_TC_DIV:   if (step_r == STEP_W'(DQ_W - 1)) state_nxt = S_RESULT;
      S_RESULT:   if (can_load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == S_IDLE);
    out_valid      = out_valid_r;
    out_temp_centi = out_temp_r;
    out_of_range   = out_oor_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      sample_count_r <= 8'd50;
      series_r       <= 20'd100000;
      nominal_r      <= 20'd100000;
      beta_r         <= 14'd3760;
      nc_r           <= 7'd25;
      sum_r          <= '0;
      counter_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_COUNT:    sample_count_r <= cfg_wdata[CNT_W-1:0];
          CFG_SERIES_OHMS:     series_r       <= cfg_wdata[OHM_W-1:0];
          CFG_NOMINAL_OHMS:    nominal_r      <= cfg_wdata[OHM_W-1:0];
          CFG_BETA_VALUE:      beta_r         <= cfg_wdata[BETA_W-1:0];
          CFG_NOMINAL_CELSIUS: nc_r           <= cfg_wdata[NC_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (emit) begin
          sum_r     <= '0;
          counter_r <= '0;
        end else begin
          sum_r     <= sum_sat;
          counter_r <= cnt_inc;
        end
      end
      if (state_r == S_RESULT && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept && emit) begin
          q_r    <= {sum_sat, (DQ_W-SUM_W)'(0)};
          rem_r  <= '0;
          dv_r   <= DR_W'(cnt_inc);
          step_r <= '0;
        end
      end
      S_AVG_DIV, S_TC_DIV: begin
        q_r    <= q_step;
        rem_r  <= div_rem;
        step_r <= step_r + 1'b1;
        if (state_r == S_TC_DIV) begin
          res_temp_r <= tc_temp;
          res_oor_r  <= 1'b0;
        end
      end
      S_CHECK: begin
        avg_r      <= avg_div;
        res_temp_r <= TEMP_MIN;
        res_oor_r  <= 1'b1;
        a_r        <= MA_W'(ser_eff);
        b_r        <= MB_W'(avg_div[15:0]);
        prod_r     <= '0;
        step_r     <= '0;
        sel_r      <= 2'd0;
      end
      S_MUL_RA, S_LOG_SQ, S_LN_MUL, S_DEN_MUL, S_BS_MUL, S_NUM_MUL: begin
        prod_r <= prod_step;
        b_r    <= b_r >> DIG_W;
        step_r <= step_r + 1'b1;
        if (mul_last) begin
          case (state_r)
            S_MUL_RA: begin
              xn_r <= XN_W'(prod_step[35:0]);
              k_r  <= K_W'(XN_W - 1);
            end
            S_DEN_MUL: begin
              den_r  <= lr_r[LR_W-1] ? -$signed(DEN_W'(prod_step[39:0]))
                                     : $signed(DEN_W'(prod_step[39:0]));
              a_r    <= MA_W'(beta_eff);
              b_r    <= MB_W'(SCALE_Q16_CENTI);
              prod_r <= '0;
              step_r <= '0;
            end
            S_BS_MUL: begin
              den_r  <= den_r + $signed(DEN_W'(prod_step[36:0]));
              a_r    <= MA_W'(prod_step[36:0]);
              b_r    <= MB_W'(t0c);
              prod_r <= '0;
              step_r <= '0;
            end
            S_NUM_MUL: begin
              res_temp_r <= TEMP_MAX;
              res_oor_r  <= 1'b0;
              q_r        <= {prod_step[DQ_W-2:0], 1'b0} + DQ_W'(den_r);
              rem_r      <= '0;
              dv_r       <= {den_r, 1'b0};
              step_r     <= '0;
            end
            default: ;
          endcase
        end
      end
      S_LOG_NORM: begin
        if (xn_r[XN_W-1]) begin
          a_r    <= MA_W'(xn_r[XN_W-1:XN_W-31]);
          b_r    <= MB_W'(xn_r[XN_W-1:XN_W-31]);
          prod_r <= '0;
          step_r <= '0;
          frac_r <= '0;
          it_r   <= '0;
        end else begin
          xn_r <= xn_r << 1;
          k_r  <= k_r - 1'b1;
        end
      end
      S_LOG_BIT: begin
        frac_r <= frac_new;
        it_r   <= it_r + 1'b1;
        prod_r <= '0;
        step_r <= '0;
        if (it_r == '1) begin
          a_r <= MA_W'({k_r, frac_new});
          b_r <= LN2_Q32;
        end else begin
          a_r <= MA_W'(m_new);
          b_r <= MB_W'(m_new);
        end
      end
      S_LN_ACC: begin
        lr_r  <= lr_acc;
        sel_r <= sel_r + 1'b1;
        k_r   <= K_W'(XN_W - 1);
        if (sel_r == 2'd0) begin
          xn_r <= XN_W'(FULL - avg_r);
        end else begin
          xn_r <= XN_W'(nom_eff);
        end
        a_r    <= MA_W'(lr_mag);
        b_r    <= MB_W'(t0c);
        prod_r <= '0;
        step_r <= '0;
      end
      S_RESULT: begin
        if (can_load) begin
          out_temp_r <= res_temp_r;
          out_oor_r  <= res_oor_r;
        end
      end
      default: ;
    endcase
  end

  // The mantissa being squared is always normalized to [1.0, 2.0).
  a_norm_mantissa: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOG_SQ |-> a_r[30] && a_r[MA_W-1:31] == '0)
    else $error("log mantissa not normalized");

  a_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    counter_r != '1)
    else $error("sample counter reached its wrap value");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_temp_r >= TEMP_MIN && out_temp_r <= TEMP_MAX)
    else $error("temperature outside saturation limits");

  a_oor_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_oor_r |-> out_temp_r == TEMP_MIN)
    else $error("out-of-range result with wrong temperature");

  a_result_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESULT && out_valid_r && !out_ready |=> state_r == S_RESULT)
    else $error("finished result dropped while output stalled");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tac_pkg::*;

  localparam int FULL_SCALE = 1023;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 500;

  class celsius_scoreboard;
    int unsigned count_cfg;
    longint unsigned series_cfg;
    longint unsigned nominal_cfg;
    longint unsigned beta_cfg;
    longint unsigned celsius_cfg;
    int unsigned sum_acc;
    int unsigned counter_acc;
    logic signed [TEMP_W-1:0] temp_q[$];
    logic oor_q[$];
    int errors;

    function new();
      count_cfg = 50;
      series_cfg = 100000;
      nominal_cfg = 100000;
      beta_cfg = 3760;
      celsius_cfg = 25;
      sum_acc = 0;
      counter_acc = 0;
      errors = 0;
    endfunction

    function void apply_cfg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_SAMPLE_COUNT: count_cfg = val[7:0];
        CFG_SERIES_OHMS: series_cfg = val[19:0];
        CFG_NOMINAL_OHMS: nominal_cfg = val[19:0];
        CFG_BETA_VALUE: beta_cfg = val[13:0];
        CFG_NOMINAL_CELSIUS: celsius_cfg = val[6:0];
        default: ;
      endcase
    endfunction

    function longint unsigned log2_fixed(longint unsigned x);
      int k;
      longint unsigned m;
      longint unsigned frac;
      if (x == 0) x = 1;
      k = 0;
      frac = 0;
      while (k < 62 && (x >> k) > 1) k++;
      m = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          frac = frac | 1;
        end
      end
      return (longint'(k) << 16) | frac;
    endfunction

    function longint ln_fixed(longint unsigned x);
      longint unsigned l2;
      l2 = log2_fixed(x);
      return longint'((l2 * 64'd2977044472 + (64'd1 << 31)) >> 32);
    endfunction

    function longint temp_from_avg(longint unsigned avg);
      longint unsigned ser;
      longint unsigned nom;
      longint beta;
      longint t0c;
      longint lr;
      longint num;
      longint den;
      longint t;
      ser = series_cfg ? series_cfg : 1;
      nom = nominal_cfg ? nominal_cfg : 1;
      beta = beta_cfg ? longint'(beta_cfg) : 1;
      t0c = longint'(celsius_cfg) * 100 + 27315;
      lr = ln_fixed(ser * avg) - ln_fixed(FULL_SCALE - avg) - ln_fixed(nom);
      num = 64'sd6553600 * beta * t0c;
      den = lr * t0c + 64'sd6553600 * beta;
      if (den <= 0) return 30000;
      t = (2 * num + den) / (2 * den) - 27315;
      if (t < -27315) t = -27315;
      if (t > 30000) t = 30000;
      return t;
    endfunction

    function void note_sample(logic [9:0] sample);
      int unsigned target;
      int unsigned avg;
      longint t;
      logic oor;
      target = count_cfg ? count_cfg : 1;
      sum_acc = sum_acc + sample;
      if (sum_acc > 262143) sum_acc = 262143;
      counter_acc = (counter_acc + 1) & 8'hFF;
      if (counter_acc == 0 || counter_acc < target) return;
      avg = sum_acc / counter_acc;
      oor = 1'b0;
      if (avg == 0 || avg >= FULL_SCALE) begin
        oor = 1'b1;
        t = -27315;
      end else begin
        t = temp_from_avg(avg);
      end
      temp_q.push_back(TEMP_W'(t));
      oor_q.push_back(oor);
      sum_acc = 0;
      counter_acc = 0;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic signed [TEMP_W-1:0] temp, logic oor);
      logic signed [TEMP_W-1:0] exp_temp;
      logic exp_oor;
      if (temp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result temp=%0d oor=%0b", temp, oor));
        return;
      end
      exp_temp = temp_q.pop_front();
      exp_oor = oor_q.pop_front();
      if (temp !== exp_temp)
        report_mismatch($sformatf("temp_centi got %0d want %0d", temp, exp_temp));
      if (oor !== exp_oor)
        report_mismatch($sformatf("out_of_range got %0b want %0b", oor, exp_oor));
    endtask

    function int pending();
      return temp_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [9:0] in_adc_sample;
  logic out_valid;
  logic out_ready;
  logic signed [TEMP_W-1:0] out_temp_centi;
  logic out_of_range;

  celsius_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  bit rx_hold;
  int unsigned cycles;

  thermistor_average_to_celsius DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_adc_sample(in_adc_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_temp_centi(out_temp_centi),
    .out_of_range(out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_sample(in_adc_sample);
    if (rst_n && out_valid && out_ready) sb.check_result(out_temp_centi, out_of_range);
  end

  always @(negedge clk) begin
    if (!rst_n || rx_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.apply_cfg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task send_sample(logic [9:0] val);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_adc_sample = val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task hold_receiver(int n);
    rx_hold = 1'b1;
    repeat (n) @(posedge clk);
    rx_hold = 1'b0;
  endtask

  task random_cfg();
    int c;
    c = $urandom_range(99);
    if (c < 70) write_reg(CFG_SAMPLE_COUNT, CFG_W'($urandom_range(6, 1)));
    else if (c < 85) write_reg(CFG_SAMPLE_COUNT, CFG_W'($urandom_range(40, 7)));
    else if (c < 92) write_reg(CFG_SAMPLE_COUNT, 0);
    else write_reg(CFG_SAMPLE_COUNT, CFG_W'($urandom_range(255, 200)));
    write_reg(CFG_SERIES_OHMS, CFG_W'(($urandom_range(3) == 0) ?
              $urandom_range(1000000, 0) : $urandom_range(200000, 1000)));
    write_reg(CFG_NOMINAL_OHMS, CFG_W'(($urandom_range(3) == 0) ?
              $urandom_range(1000000, 0) : $urandom_range(200000, 1000)));
    write_reg(CFG_BETA_VALUE, CFG_W'(($urandom_range(3) == 0) ?
              $urandom_range(10000, 0) : $urandom_range(4500, 3000)));
    write_reg(CFG_NOMINAL_CELSIUS, CFG_W'($urandom_range(100, 0)));
  endtask

  task random_block(int n);
    int centre;
    centre = $urandom_range(FULL_SCALE);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: send_sample(10'($urandom_range(FULL_SCALE)));
        1: send_sample(($urandom_range(1)) ? 10'd0 : 10'd1023);
        default: send_sample((centre + $urandom_range(40) > 20 + FULL_SCALE) ? 10'd1023 :
                             ((centre + $urandom_range(40) < 20) ? 10'd0 :
                              10'(centre + $urandom_range(40) - 20)));
      endcase
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_adc_sample = '0;
    out_ready = 1'b0;
    rx_hold = 1'b0;
    send_idle_pct = 12;
    recv_idle_pct = 46;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Default settings first, then extremes of every register.
    random_block(50);
    drain();
    write_reg(CFG_SAMPLE_COUNT, 1);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd1);
    send_sample(10'd1022);
    send_sample(10'd512);
    send_sample(10'h2AA);
    send_sample(10'h155);
    drain();
    write_reg(CFG_SERIES_OHMS, 1);
    write_reg(CFG_NOMINAL_OHMS, 1000000);
    write_reg(CFG_BETA_VALUE, 1);
    write_reg(CFG_NOMINAL_CELSIUS, 0);
    send_sample(10'd1);
    send_sample(10'd700);
    drain();
    write_reg(CFG_SERIES_OHMS, 1000000);
    write_reg(CFG_NOMINAL_OHMS, 1);
    write_reg(CFG_BETA_VALUE, 10000);
    write_reg(CFG_NOMINAL_CELSIUS, 100);
    send_sample(10'd1022);
    send_sample(10'd3);
    drain();
    write_reg(CFG_SAMPLE_COUNT, 0);
    write_reg(CFG_SERIES_OHMS, 0);
    write_reg(CFG_NOMINAL_OHMS, 0);
    write_reg(CFG_BETA_VALUE, 0);
    write_reg(3'd5, 20'hFFFFF);
    write_reg(3'd6, 20'h00001);
    write_reg(3'd7, 20'h7FFFF);
    send_sample(10'd300);
    send_sample(10'd900);
    drain();
    write_reg(CFG_SAMPLE_COUNT, 255);
    write_reg(CFG_SERIES_OHMS, 100000);
    write_reg(CFG_NOMINAL_OHMS, 100000);
    write_reg(CFG_BETA_VALUE, 3950);
    write_reg(CFG_NOMINAL_CELSIUS, 25);
    for (int i = 0; i < 255; i++) send_sample(10'd1023);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 12 : ((mode == 1) ? 46 : 0);
      recv_idle_pct = (mode == 0) ? 46 : ((mode == 1) ? 12 : 0);
      if (mode == 1) begin
        write_reg(CFG_SAMPLE_COUNT, 1);
        fork
          hold_receiver(3000);
          random_block(20);
        join
        drain();
      end
      for (int p = 0; p < 4; p++) begin
        random_cfg();
        random_block($urandom_range(12, 4));
        drain();
      end
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/tac_pkg.sv
hdl/thermistor_average_to_celsius.sv
tb/tb_top.sv
